>>> rtl/sm4rf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sm4rf_pkg;

    typedef enum logic {
        ACT_CIPHER = 1'b0,
        ACT_KEY    = 1'b1
    } t_action;

    typedef struct packed {
        t_action     action;
        logic [31:0] word_zero;
        logic [31:0] word_one;
        logic [31:0] word_two;
        logic [31:0] word_three;
        logic [31:0] key_word;
    } t_in_item;

    typedef struct packed {
        logic [31:0] new_word;
    } t_out_item;

    localparam int unsigned ROT_C0 = 2;
    localparam int unsigned ROT_C1 = 10;
    localparam int unsigned ROT_C2 = 18;
    localparam int unsigned ROT_C3 = 24;
    localparam int unsigned ROT_K0 = 13;
    localparam int unsigned ROT_K1 = 23;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] sm4_tau(input logic [31:0] v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned amt);
        return (v << amt) | (v >> (32 - amt));
    endfunction

endpackage

`default_nettype wire

>>> rtl/sm4rf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sm4rf_in_if;
    import sm4rf_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/sm4rf_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sm4rf_out_if;
    import sm4rf_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/sm4_round_function.sv
// SM4 round word unit.
// Input channel i_in carries the action bit (cipher or key expansion), the
// four state words and a round key or key-schedule constant. Output channel
// o_out carries the new state word, one per input transfer, in input order.
// Three register stages: key mix, byte S-box, then linear transform with the
// XOR of word zero into the output register. Throughput is one item per
// clock cycle while o_out.ready is high; each stage advances whenever it is
// empty or the stage after it advances, so the pipe stays full back to back.
// When the receiver holds o_out.ready low, results stay in place and the
// stages fill up; i_in.ready drops once all three hold items, and nothing is
// lost or repeated. The stall reaches i_in.ready in the same cycle.
// Synchronous reset (i_rst_n low) empties the pipeline; items in flight are
// dropped. The block keeps no other state.
`timescale 1ns / 1ps
`default_nettype none

module sm4_round_function (
    input  wire         i_clk,
    input  wire         i_rst_n,
    sm4rf_in_if.sink    i_in,
    sm4rf_out_if.source o_out
);
    import sm4rf_pkg::*;

    logic        r_v1;
    t_action     r_act1;
    logic [31:0] r_w0_1;
    logic [31:0] r_mix1;

    logic        r_v2;
    t_action     r_act2;
    logic [31:0] r_w0_2;
    logic [31:0] r_b2;

    logic        r_v3;
    logic [31:0] r_res3;

    logic        en1;
    logic        en2;
    logic        en3;
    logic [31:0] n_res3;

    assign en3 = !r_v3 || o_out.ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign i_in.ready      = en1;
    assign o_out.valid     = r_v3;
    assign o_out.data      = '{new_word: r_res3};

    always_comb begin
        if (r_act2 == ACT_KEY) begin
            n_res3 = r_w0_2 ^ r_b2 ^ rotl32(r_b2, ROT_K0) ^ rotl32(r_b2, ROT_K1);
        end else begin
            n_res3 = r_w0_2 ^ r_b2 ^ rotl32(r_b2, ROT_C0) ^ rotl32(r_b2, ROT_C1)
                   ^ rotl32(r_b2, ROT_C2) ^ rotl32(r_b2, ROT_C3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_act1 <= i_in.data.action;
            r_w0_1 <= i_in.data.word_zero;
            r_mix1 <= i_in.data.word_one ^ i_in.data.word_two
                    ^ i_in.data.word_three ^ i_in.data.key_word;
        end
        if (en2) begin
            r_act2 <= r_act1;
            r_w0_2 <= r_w0_1;
            r_b2   <= sm4_tau(r_mix1);
        end
        if (en3) begin
            r_res3 <= n_res3;
        end
    end

`ifndef SYNTHESIS
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_v1 && !r_v2 && !r_v3)
        else $error("pipeline not empty after reset");

    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_v1)
        else $error("input transfer did not reach first stage");

    a_mid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !en3 |=> r_v2 && $stable(r_b2) && $stable(r_w0_2))
        else $error("middle stage changed while stalled");

    a_sbox_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && en2 |=> r_v2 && r_b2 == sm4_tau($past(r_mix1)))
        else $error("S-box stage mismatch");
`endif

endmodule

`default_nettype wire
